@@ src/rle_pkg.sv @@
// ----------------------------------------------------------------------------
// RLE decoder package
// Shared widths, the decode mode type and the beat structs of the run-length
// decoder.
// ----------------------------------------------------------------------------
package rle_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned LenW   = 7;
  localparam int unsigned CountW = 13;

  // Control byte layout
  localparam int unsigned      RepeatBit = 7;
  localparam logic [LenW-1:0]  LenMask   = 7'h7F;

  localparam logic [CountW-1:0] CapResetVal = 13'd256;

  typedef enum logic [1:0] {
    MODE_CONTROL = 2'd0,
    MODE_REPEAT  = 2'd1,
    MODE_LITERAL = 2'd2
  } dec_mode_e;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             final_byte;
  } in_beat_t;

  typedef struct packed {
    logic [ByteW-1:0]  pixel_value;
    logic [LenW-1:0]   run_count;
    logic              block_end;
    logic [CountW-1:0] total_written;
  } out_beat_t;

endpackage

@@ src/rle_if.sv @@
// ----------------------------------------------------------------------------
// RLE decoder channels
// Valid/ready channels for compressed input bytes and decoded result beats.
// ----------------------------------------------------------------------------
interface rle_in_if;
  import rle_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface rle_out_if;
  import rle_pkg::*;

  logic              valid;
  logic              ready;
  logic [ByteW-1:0]  pixel_value;
  logic [LenW-1:0]   run_count;
  logic              block_end;
  logic [CountW-1:0] total_written;

  modport source (output valid, output pixel_value, output run_count,
                  output block_end, output total_written, input ready);
  modport sink   (input valid, input pixel_value, input run_count,
                  input block_end, input total_written, output ready);
endinterface

@@ src/rle_run_decoder.sv @@
// ----------------------------------------------------------------------------
// Run-length decoder, packbits style
// Top level: capacity register, decode core and output stage.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one compressed byte per beat with a flag on the last byte of
//   a block. A control byte selects a repeat run (bit 7 set) or a literal run
//   and gives the length in bits 6-0; zero-length controls are skipped.
//   out_o carries one beat per value byte (pixel plus run count, clipped to
//   the capacity) and one block-end beat for the final byte, with the total.
//   Control and ignored bytes produce no beat unless they are final.
//   cfg_we_i/cfg_wdata_i write the output capacity; write only while idle.
// Timing:
//   A result beat goes to the output register, or to the skid entry when
//   out_o stalls. One byte per cycle while the skid is empty: the decode
//   is one combinational step between input handshake and output register.
// Stall:
//   A one-entry skid behind the output register absorbs a single stalled
//   result; in_i.ready drops only while that entry is occupied.
// Reset:
//   Capacity returns to 256, the decoder expects a control byte with a zero
//   total, and both output entries are emptied.
// ----------------------------------------------------------------------------
module rle_run_decoder #(
  parameter int unsigned MAX_CAPACITY = 4096
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [rle_pkg::CountW-1:0] cfg_wdata_i,
  rle_in_if.sink                     in_i,
  rle_out_if.source                  out_o
);
  import rle_pkg::*;

  logic [CountW-1:0] capacity_q;
  logic              accept;
  logic              push_ready;
  logic              res_valid;
  in_beat_t          in_beat;
  out_beat_t         res_beat;

  // Capacity register: take the write data whenever enabled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CapResetVal;
    end else if (cfg_we_i) begin
      capacity_q <= cfg_wdata_i;
    end
  end

  // Advance the decoder on every accepted input beat
  assign in_i.ready         = push_ready;
  assign accept             = in_i.valid && push_ready;
  assign in_beat.data_byte  = in_i.data_byte;
  assign in_beat.final_byte = in_i.final_byte;

  rle_dec_core #(
    .MAX_CAPACITY (MAX_CAPACITY)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .beat_i      (in_beat),
    .capacity_i  (capacity_q),
    .res_valid_o (res_valid),
    .res_o       (res_beat)
  );

  // Hold results in the output register; spill one into the skid on a stall
  rle_out_skid u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (res_valid),
    .push_beat_i  (res_beat),
    .push_ready_o (push_ready),
    .out_o        (out_o)
  );

endmodule

@@ src/rle_dec_core.sv @@
// ----------------------------------------------------------------------------
// RLE decode core
// Decode state and one-byte-per-cycle result logic, while input is accepted.
// ----------------------------------------------------------------------------
module rle_dec_core #(
  parameter int unsigned MAX_CAPACITY = 4096
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             accept_i,
  input  rle_pkg::in_beat_t                beat_i,
  input  logic [rle_pkg::CountW-1:0]       capacity_i,
  output logic                             res_valid_o,
  output rle_pkg::out_beat_t               res_o
);
  import rle_pkg::*;

  // Largest value the capacity register can hold limits the clamp
  localparam int unsigned RegMax   = (1 << CountW) - 1;
  localparam int unsigned ClampVal = (MAX_CAPACITY > RegMax) ? RegMax : MAX_CAPACITY;
  localparam logic [CountW-1:0] CapLimit = CountW'(ClampVal);

  dec_mode_e         mode_q, mode_d;
  logic [LenW-1:0]   lit_rem_q, lit_rem_d;
  logic [LenW-1:0]   rep_len_q, rep_len_d;
  logic [CountW-1:0] written_q, written_d;

  logic [CountW-1:0] cap_eff;
  logic [CountW-1:0] room;
  logic [CountW-1:0] rep_ext;
  logic [LenW-1:0]   cnt;
  logic [LenW-1:0]   len;
  logic [LenW-1:0]   lit_dec;
  logic              emit;

  assign cap_eff = (capacity_i > CapLimit) ? CapLimit : capacity_i;
  assign room    = cap_eff - written_q;
  assign rep_ext = CountW'(rep_len_q);
  assign len     = beat_i.data_byte[LenW-1:0] & LenMask;
  assign lit_dec = lit_rem_q - LenW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_CONTROL;
      lit_rem_q <= '0;
      rep_len_q <= '0;
      written_q <= '0;
    end else begin
      mode_q    <= mode_d;
      lit_rem_q <= lit_rem_d;
      rep_len_q <= rep_len_d;
      written_q <= written_d;
    end
  end

  always_comb begin
    mode_d    = mode_q;
    lit_rem_d = lit_rem_q;
    rep_len_d = rep_len_q;
    written_d = written_q;
    cnt       = '0;
    emit      = 1'b0;

    if (accept_i) begin
      // Ignore everything but the final flag once the output is full
      if (written_q < cap_eff) begin
        case (mode_q)
          MODE_REPEAT: begin
            cnt       = (rep_ext > room) ? room[LenW-1:0] : rep_len_q;
            emit      = 1'b1;
            written_d = written_q + CountW'(cnt);
            rep_len_d = '0;
            mode_d    = MODE_CONTROL;
          end
          MODE_LITERAL: begin
            cnt       = LenW'(1);
            emit      = 1'b1;
            written_d = written_q + CountW'(1);
            lit_rem_d = lit_dec;
            if (lit_dec == '0) begin
              mode_d = MODE_CONTROL;
            end
          end
          default: begin
            mode_d = MODE_CONTROL;
            if (len != '0) begin
              if (beat_i.data_byte[RepeatBit]) begin
                rep_len_d = len;
                mode_d    = MODE_REPEAT;
              end else begin
                lit_rem_d = len;
                mode_d    = MODE_LITERAL;
              end
            end
          end
        endcase
      end
      if (beat_i.final_byte) begin
        mode_d    = MODE_CONTROL;
        lit_rem_d = '0;
        rep_len_d = '0;
        written_d = '0;
      end
    end
  end

  assign res_valid_o        = accept_i && (emit || beat_i.final_byte);
  assign res_o.pixel_value  = emit ? beat_i.data_byte : '0;
  assign res_o.run_count    = cnt;
  assign res_o.block_end    = beat_i.final_byte;
  assign res_o.total_written = beat_i.final_byte ?
                               ((written_q < cap_eff && (mode_q == MODE_REPEAT ||
                                 mode_q == MODE_LITERAL)) ?
                                (written_q + CountW'(cnt)) : written_q) :
                               written_d;

  a_lit_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_LITERAL |-> lit_rem_q != '0)
    else $error("literal mode with no bytes left");

  a_rep_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_REPEAT |-> rep_len_q != '0)
    else $error("repeat mode with zero length");

  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && beat_i.final_byte |=> written_q == '0 && mode_q == MODE_CONTROL)
    else $error("block state not cleared after final byte");

  a_final_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && beat_i.final_byte |-> res_valid_o && res_o.block_end)
    else $error("final byte gave no block-end result");

endmodule

@@ src/rle_out_skid.sv @@
// ----------------------------------------------------------------------------
// RLE output stage
// Output register plus one skid entry, which takes one result under a stall.
// ----------------------------------------------------------------------------
module rle_out_skid (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  rle_pkg::out_beat_t push_beat_i,
  output logic               push_ready_o,
  rle_out_if.source          out_o
);
  import rle_pkg::*;

  logic      out_vld_q, out_vld_d;
  logic      skid_vld_q, skid_vld_d;
  out_beat_t out_beat_q, out_beat_d;
  out_beat_t skid_beat_q, skid_beat_d;
  logic      out_free;

  assign out_free     = !out_vld_q || out_o.ready;
  assign push_ready_o = !skid_vld_q;

  always_comb begin
    out_vld_d   = out_vld_q;
    skid_vld_d  = skid_vld_q;
    out_beat_d  = out_beat_q;
    skid_beat_d = skid_beat_q;
    if (out_free) begin
      // Drain the skid entry first; a push cannot coincide with it
      if (skid_vld_q) begin
        out_vld_d  = 1'b1;
        out_beat_d = skid_beat_q;
        skid_vld_d = 1'b0;
      end else begin
        out_vld_d  = push_i;
        out_beat_d = push_beat_i;
      end
    end else if (push_i) begin
      skid_vld_d  = 1'b1;
      skid_beat_d = push_beat_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_beat_q  <= out_beat_d;
    skid_beat_q <= skid_beat_d;
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.pixel_value   = out_beat_q.pixel_value;
  assign out_o.run_count     = out_beat_q.run_count;
  assign out_o.block_end     = out_beat_q.block_end;
  assign out_o.total_written = out_beat_q.total_written;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry held while output register empty");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !skid_vld_q)
    else $error("result pushed into a full skid entry");

endmodule

@@ tb/tb_rle_run_decoder.sv @@
// ----------------------------------------------------------------------------
// Run-length decoder testbench
// Feeds compressed bytes through the decoder under several capacity settings
// and stall patterns. A behavioural copy of the decoder inside the bench
// predicts every result beat, and each beat taken from the output channel is
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_rle_run_decoder;
  import rle_pkg::*;

  // The instance keeps its default capacity ceiling; mirror it here.
  localparam int unsigned CapCeiling   = 4096;
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned ReportLimit  = 40;

  logic              clk_i  = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i;
  logic [CountW-1:0] cfg_wdata_i;

  rle_in_if  in_ch ();
  rle_out_if out_ch ();

  rle_run_decoder #(
    .MAX_CAPACITY(CapCeiling)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  in_beat_t    pending_bytes[$];   // compressed bytes not yet offered
  out_beat_t   expected_runs[$];   // predicted result beats, oldest first
  out_beat_t   seen_beat;
  out_beat_t   want_beat;
  out_beat_t   predicted_beat;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_arm       = 1'b0;
  int unsigned hold_left;
  int unsigned cycle_count    = 0;

  int unsigned queued_total    = 0;
  int unsigned accepted_bytes  = 0;
  int unsigned results_checked = 0;
  int unsigned block_ends_seen = 0;
  int unsigned clipped_runs    = 0;
  int unsigned mismatches      = 0;

  // Decoder copy: mode, run bookkeeping, running total and the capacity
  dec_mode_e         mdl_mode;
  logic [LenW-1:0]   mdl_lit_left;
  logic [LenW-1:0]   mdl_rep_len;
  logic [CountW-1:0] mdl_total;
  logic [CountW-1:0] mdl_capacity;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic void restart_block();
    mdl_mode     = MODE_CONTROL;
    mdl_lit_left = '0;
    mdl_rep_len  = '0;
    mdl_total    = '0;
  endfunction

  // Advance the decoder copy by one byte; return 1 when the byte yields a beat.
  function automatic bit decode_byte(input in_beat_t ib, output out_beat_t ob);
    logic [CountW-1:0] cap_eff;
    logic [CountW-1:0] room;
    logic [LenW-1:0]   len;
    bit                emit;
    cap_eff = (mdl_capacity > CountW'(CapCeiling)) ? CountW'(CapCeiling) : mdl_capacity;
    emit    = 1'b0;
    ob      = '0;
    // A full block (or zero capacity) ignores every byte; only the flag acts.
    if (mdl_total < cap_eff) begin
      room = cap_eff - mdl_total;
      case (mdl_mode)
        MODE_REPEAT: begin
          ob.pixel_value = ib.data_byte;
          if (CountW'(mdl_rep_len) > room) begin
            ob.run_count = room[LenW-1:0];
            clipped_runs++;
          end else begin
            ob.run_count = mdl_rep_len;
          end
          emit        = 1'b1;
          mdl_total   = mdl_total + CountW'(ob.run_count);
          mdl_rep_len = '0;
          mdl_mode    = MODE_CONTROL;
        end
        MODE_LITERAL: begin
          ob.pixel_value = ib.data_byte;
          ob.run_count   = LenW'(1);
          emit           = 1'b1;
          mdl_total      = mdl_total + 1'b1;
          mdl_lit_left   = mdl_lit_left - 1'b1;
          if (mdl_lit_left == '0) begin
            mdl_mode = MODE_CONTROL;
          end
        end
        default: begin
          // Control byte; a zero length leaves the mode untouched.
          len      = ib.data_byte[LenW-1:0] & LenMask;
          mdl_mode = MODE_CONTROL;
          if (len != '0) begin
            if (ib.data_byte[RepeatBit]) begin
              mdl_rep_len = len;
              mdl_mode    = MODE_REPEAT;
            end else begin
              mdl_lit_left = len;
              mdl_mode     = MODE_LITERAL;
            end
          end
        end
      endcase
    end
    ob.block_end     = ib.final_byte;
    ob.total_written = mdl_total;
    if (ib.final_byte) begin
      restart_block();
    end
    return emit || ib.final_byte;
  endfunction

  // --------------------------------------------------------------------------
  // Clock and cycle guard
  // --------------------------------------------------------------------------
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("%0t: run did not drain within %0d cycles", $time, CycleLimit);
      $display("rle_run_decoder: mismatch");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Byte driver: offer the next pending byte, predict on every taken beat
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : byte_driver
    if (!rst_ni) begin
      in_ch.valid      <= 1'b0;
      in_ch.data_byte  <= '0;
      in_ch.final_byte <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        accepted_bytes++;
        if (decode_byte('{in_ch.data_byte, in_ch.final_byte}, predicted_beat)) begin
          expected_runs.push_back(predicted_beat);
        end
      end
      // Hold the current beat while it is stalled; otherwise advance or idle.
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_ch.valid      <= 1'b1;
          in_ch.data_byte  <= pending_bytes[0].data_byte;
          in_ch.final_byte <= pending_bytes[0].final_byte;
          void'(pending_bytes.pop_front());
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Long hold-off of the receiver, counted on its own
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : hold_counter
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_arm) begin
      hold_left <= HoldCycles;
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: compare each taken beat with the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        seen_beat = '{out_ch.pixel_value, out_ch.run_count, out_ch.block_end,
                      out_ch.total_written};
        results_checked++;
        if (seen_beat.block_end) begin
          block_ends_seen++;
        end
        if (expected_runs.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportLimit) begin
            $display("%0t: beat with nothing expected: pixel %02h count %0d end %b total %0d",
                     $time, seen_beat.pixel_value, seen_beat.run_count,
                     seen_beat.block_end, seen_beat.total_written);
          end
        end else begin
          want_beat = expected_runs.pop_front();
          if (seen_beat !== want_beat) begin
            mismatches++;
            if (mismatches <= ReportLimit) begin
              $display("%0t: expected pixel %02h count %0d end %b total %0d, got pixel %02h count %0d end %b total %0d",
                       $time, want_beat.pixel_value, want_beat.run_count,
                       want_beat.block_end, want_beat.total_written,
                       seen_beat.pixel_value, seen_beat.run_count,
                       seen_beat.block_end, seen_beat.total_written);
            end
          end
        end
      end
      out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic queue_byte(input logic [ByteW-1:0] d, input logic fin);
    pending_bytes.push_back('{d, fin});
    queued_total++;
  endtask

  // Well-formed block: a handful of runs, final flag on the last byte.
  task automatic queue_block();
    int unsigned runs;
    int unsigned len;
    int unsigned roll;
    bit          last;
    runs = $urandom_range(5, 1);
    for (int unsigned r = 0; r < runs; r++) begin
      last = (r == runs - 1);
      roll = $urandom_range(99);
      if (roll < 10)      len = 0;
      else if (roll < 75) len = $urandom_range(8, 1);
      else if (roll < 95) len = $urandom_range(40, 9);
      else                len = $urandom_range(127, 41);
      if ($urandom_range(1)) begin
        queue_byte({1'b1, LenW'(len)}, last && len == 0);
        if (len != 0) queue_byte(ByteW'($urandom_range(255)), last);
      end else begin
        // Keep long literal runs rare; they cost one beat per pixel.
        if (len > 40 && $urandom_range(3) != 0) len = $urandom_range(40, 9);
        queue_byte({1'b0, LenW'(len)}, last && len == 0);
        for (int unsigned i = 0; i < len; i++) begin
          queue_byte(ByteW'($urandom_range(255)), last && i == len - 1);
        end
      end
    end
  endtask

  // Broken block: raw noise, or a run cut short by the final flag.
  task automatic queue_broken_block();
    int unsigned n;
    if ($urandom_range(1)) begin
      n = $urandom_range(10, 1);
      for (int unsigned i = 0; i < n; i++) begin
        queue_byte(ByteW'($urandom_range(255)), i == n - 1);
      end
    end else begin
      n = $urandom_range(20, 2);
      if ($urandom_range(1)) begin
        // repeat control carrying the flag itself
        queue_byte({1'b1, LenW'(n)}, 1'b1);
      end else begin
        queue_byte({1'b0, LenW'(n)}, 1'b0);
        n = $urandom_range(n - 1, 1);
        for (int unsigned i = 0; i < n; i++) begin
          queue_byte(ByteW'($urandom_range(255)), i == n - 1);
        end
      end
    end
  endtask

  task automatic queue_random(input int unsigned beats);
    int unsigned start;
    start = queued_total;
    while (queued_total - start < beats) begin
      if ($urandom_range(99) < 80) queue_block();
      else                         queue_broken_block();
    end
  endtask

  task automatic wait_idle();
    while (pending_bytes.size() != 0 || in_ch.valid || expected_runs.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Drain, write the capacity, set the stall mix and load random blocks.
  task automatic run_phase(input logic [CountW-1:0] cap, input int unsigned send_idle,
                           input int unsigned recv_stall, input int unsigned beats);
    wait_idle();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    mdl_capacity  = cap;
    @(negedge clk_i);
    send_idle_pct  = send_idle;
    recv_stall_pct = recv_stall;
    queue_random(beats);
  endtask

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = '0;
    in_ch.final_byte = 1'b0;
    out_ch.ready     = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = '0;
    mdl_capacity     = CapResetVal;
    restart_block();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed blocks at the reset capacity of 256
    queue_byte(8'h00, 1'b0);                         // zero-length literal, skipped
    queue_byte(8'h80, 1'b0);                         // zero-length repeat, skipped
    queue_byte(8'h83, 1'b0);  queue_byte(8'hFF, 1'b0);
    queue_byte(8'h02, 1'b0);  queue_byte(8'h00, 1'b0);  queue_byte(8'hAA, 1'b0);
    queue_byte(8'hFF, 1'b0);  queue_byte(8'h55, 1'b0);   // full-length repeat
    queue_byte(8'hFF, 1'b0);  queue_byte(8'h11, 1'b0);   // clipped at capacity
    queue_byte(8'h05, 1'b0);  queue_byte(8'h37, 1'b0);   // ignored once full
    queue_byte(8'h42, 1'b1);                         // flag on an ignored byte
    queue_byte(8'h81, 1'b0);  queue_byte(8'h7E, 1'b1);   // flag on a value byte
    queue_byte(8'h03, 1'b0);  queue_byte(8'h01, 1'b0);
    queue_byte(8'h02, 1'b1);                         // literal cut short
    queue_byte(8'h85, 1'b1);                         // flag on a control byte
    queue_byte(8'h00, 1'b1);                         // flag on a skipped byte

    // Zero capacity: everything ignored, only the flag answers
    run_phase(CountW'(0), 0, 0, 0);
    queue_byte(8'h82, 1'b0);  queue_byte(8'h10, 1'b0);  queue_byte(8'h01, 1'b1);
    queue_random(60);

    // Oversized register value, acting as the ceiling; sender mostly idle
    run_phase(CountW'(8191), 86, 0, 150);
    // Single-pixel capacity; receiver mostly stalling
    run_phase(CountW'(1), 0, 86, 120);
    // Exact ceiling; both sides idling now and then
    run_phase(CountW'(CapCeiling), 16, 16, 150);

    // Back-pressure: hold the receiver off while the sender keeps offering
    run_phase(CountW'(256), 0, 0, 150);
    hold_arm = 1'b1;
    while (hold_left == 0) @(negedge clk_i);
    hold_arm = 1'b0;

    // Random capacities under mixed stalls
    for (int k = 0; k < 3; k++) begin
      run_phase(CountW'($urandom_range(600, 2)), $urandom_range(60), $urandom_range(60), 90);
    end

    wait_idle();
    $display("Covered %0d input beats and %0d result beats (%0d block ends, %0d clipped repeats)",
             accepted_bytes, results_checked, block_ends_seen, clipped_runs);
    $display("over capacities 256, 0, 8191, 1, 4096 and random, with idle, stall and hold-off phases.");
    if (mismatches == 0) begin
      $display("rle_run_decoder: match");
    end else begin
      $display("rle_run_decoder: mismatch");
    end
    $finish;
  end

endmodule

@@ rle_run_decoder.f @@
src/rle_pkg.sv
src/rle_if.sv
src/rle_dec_core.sv
src/rle_out_skid.sv
src/rle_run_decoder.sv
tb/tb_rle_run_decoder.sv
